[hdl/bcea_pkg.sv]
// Shared types and constants of the Birks corrected cell energy aggregator.
// Used by the controller, the datapath and the top level; no dependencies.
package bcea_pkg;

   // Command codes of the request channel
   typedef enum logic [1:0] {
      CMD_DEPOSIT = 2'd0,
      CMD_READ    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_MERGED   = 3'd0,
      ST_NEW      = 3'd1,
      ST_ZERO     = 3'd2,
      ST_FULL     = 3'd3,
      ST_READ_OK  = 3'd4,
      ST_READ_OOR = 3'd5,
      ST_CLEARED  = 3'd6
   } status_type;

   // Operation on the shared divider or multiplier
   typedef enum logic [2:0] {
      U_DEDX = 3'd1,
      U_CORR = 3'd2,
      U_T1   = 3'd3,
      U_Q    = 3'd4,
      U_T2   = 3'd5
   } unit_sel_type;

   // Configuration register indexes and reset values
   localparam logic [1:0]  REG_FIRST     = 2'd0;
   localparam logic [1:0]  REG_SECOND    = 2'd1;
   localparam logic [23:0] FIRST_RESET   = 24'd218104;
   localparam logic [31:0] SECOND_RESET  = 32'd41232;

   // Reciprocal of 7 in Q.29, rounded up; exact floor for a 26-bit dividend
   localparam logic [26:0] K1_RECIP      = 27'd76695845;
   localparam int          K1_SHIFT      = 29;
   // Saturation value of the quadratic term
   localparam logic [63:0] T2_SAT        = 64'h4000_0000_0000_0000;
   // One in Q.16
   localparam logic [63:0] ONE_Q16       = 64'h0000_0000_0001_0000;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         div_start;
      logic         mul_start;
      unit_sel_type sel;
      logic         pass_energy;
      logic         scan_start;
      logic         read_start;
      logic         out_load;
      status_type   out_status;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      command_type cmd;
      logic        e_zero;
      logic        no_corr;
      logic        div_done;
      logic        mul_done;
      logic        scan_hit;
      logic        scan_miss;
      logic        full;
      logic        read_ok;
      logic        out_free;
   } dp_status_type;

endpackage

[hdl/birks_corrected_cell_energy_aggregator.sv]
// Top level of the Birks corrected cell energy aggregator.
// Depends on bcea_pkg, bcea_ctrl and bcea_datapath.
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    command, cell, energy, step, density, charge
//  rsp_      out        rsp_valid/rsp_ready    status, entry fields, corrected energy, count
//  csr_      in         csr_valid/csr_ready    csr_index, csr_data (csr_ready always high)
//
// One command is processed at a time. A quenched deposit runs the divider and multiplier
// (two 64-step divisions, three 64-step multiplications) and then the cell walk; an
// unquenched one only the walk. The walk reads one entry per cycle through the table's
// single read port. A stalled rsp_ready holds the result register; the next request is
// still taken and waits at the end for the register to free. Synchronous reset empties
// the table at once through the fill count.
module birks_corrected_cell_energy_aggregator import bcea_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [63:0]       req_cell_id,
   input  logic [31:0]       req_energy_in,
   input  logic [23:0]       req_step_length,
   input  logic [15:0]       req_density,
   input  logic signed [4:0] req_charge,
   input  logic              req_material_match,
   input  logic [9:0]        req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [9:0]        rsp_entry_index,
   output logic [63:0]       rsp_entry_cell,
   output logic [47:0]       rsp_entry_energy,
   output logic [31:0]       rsp_corrected_energy,
   output logic [10:0]       rsp_entry_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   status_type    rsp_status_code;
   logic          in_take;

   assign csr_ready  = 1'b1;
   assign in_take    = req_valid && req_ready;
   assign rsp_status = rsp_status_code;

   bcea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcea_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .in_take              (in_take),
      .req_command          (req_command),
      .req_cell_id          (req_cell_id),
      .req_energy_in        (req_energy_in),
      .req_step_length      (req_step_length),
      .req_density          (req_density),
      .req_charge           (req_charge),
      .req_material_match   (req_material_match),
      .req_read_index       (req_read_index),
      .csr_take             (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status_code),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_entry_cell       (rsp_entry_cell),
      .rsp_entry_energy     (rsp_entry_energy),
      .rsp_corrected_energy (rsp_corrected_energy),
      .rsp_entry_count      (rsp_entry_count)
   );

endmodule

[hdl/bcea_div.sv]
// Restoring radix-2 divider, 64-bit dividend and divisor, one quotient bit a cycle.
// Depends on nothing; used by bcea_datapath.
module bcea_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] shifted;
   logic [64:0] diff;
   logic        ge;

   // One restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : shifted[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/bcea_mul.sv]
// Shift-add multiplier, 64 by 64 bits to 128 bits, one multiplier bit a cycle.
// Depends on nothing; used by bcea_datapath.
module bcea_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  mcand,
   input  logic [63:0]  mplier,
   output logic         done,
   output logic [127:0] product
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;
   logic [64:0] sum;

   // Add the multiplicand into the high half, then shift right
   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : 65'd0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mcand;
         hi_in   = '0;
         lo_in   = mplier;
      end else if (busy_ff) begin
         hi_in  = sum[64:1];
         lo_in  = {sum[0], lo_ff[63:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

[hdl/bcea_datapath.sv]
// Datapath: request and config registers, Birks arithmetic, cell table, result register.
// Depends on bcea_pkg, bcea_div and bcea_mul.
module bcea_datapath import bcea_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_take,
   input  logic [1:0]         req_command,
   input  logic [63:0]        req_cell_id,
   input  logic [31:0]        req_energy_in,
   input  logic [23:0]        req_step_length,
   input  logic [15:0]        req_density,
   input  logic signed [4:0]  req_charge,
   input  logic               req_material_match,
   input  logic [9:0]         req_read_index,
   input  logic               csr_take,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output status_type         rsp_status,
   output logic [9:0]         rsp_entry_index,
   output logic [63:0]        rsp_entry_cell,
   output logic [47:0]        rsp_entry_energy,
   output logic [31:0]        rsp_corrected_energy,
   output logic [10:0]        rsp_entry_count
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // Configuration
   logic [23:0] first_ff;
   logic [31:0] second_ff;

   // Request held for the whole command
   command_type       cmd_code_ff;
   logic [63:0]       cell_ff;
   logic [31:0]       energy_ff;
   logic [23:0]       len_ff;
   logic [15:0]       rho_ff;
   logic signed [4:0] charge_ff;
   logic              match_ff;
   logic [9:0]        ri_ff;

   // Arithmetic intermediates
   unit_sel_type sel_ff;
   logic [23:0]  k1_ff;
   logic [63:0]  dedx_ff;
   logic [63:0]  t1_ff;
   logic [63:0]  q_ff;
   logic [63:0]  t2_ff;
   logic [31:0]  corr_ff;

   // Table and its walk
   logic [63:0]   cell_mem   [TABLE_DEPTH];
   logic [47:0]   energy_mem [TABLE_DEPTH];
   logic [CW-1:0] fill_ff;
   logic          scan_active_ff;
   logic [CW-1:0] addr_ff;
   logic          rd_en_ff;
   logic [IW-1:0] rd_idx_ff;
   logic [63:0]   rd_cell_ff;
   logic [47:0]   rd_energy_ff;

   // Result register
   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   logic [9:0]  rsp_index_ff;
   logic [63:0] rsp_cell_ff;
   logic [47:0] rsp_energy_ff;
   logic [31:0] rsp_corr_ff;
   logic [10:0] rsp_count_ff;

   logic [35:0]  ten_e;
   logic [39:0]  step_d;
   logic [63:0]  den;
   logic [63:0]  div_num, div_den, quo;
   logic [63:0]  mul_a;
   logic [127:0] prod;
   logic         div_done, mul_done;
   logic         scan_hit, scan_miss, issue;
   logic [31:0]  ri32;
   logic         read_ok;
   logic [48:0]  sum49;
   logic [47:0]  sum_sat;
   logic [IW-1:0] fill_idx;
   logic         heavy_req;
   logic [52:0]  k1_prod;

   // Heavy ion scaling of the first constant (x4/7) by reciprocal multiplication
   always_comb begin
      heavy_req = (req_charge != 5'sd0) && (req_charge != 5'sd1) && (req_charge != -5'sd1);
      k1_prod   = 53'({first_ff, 2'b00}) * 53'(K1_RECIP);
   end

   // Operand selection for the shared units
   always_comb begin
      ten_e  = ({4'b0, energy_ff} << 3) + ({4'b0, energy_ff} << 1);
      step_d = 40'(len_ff) * 40'(rho_ff);
      den    = ONE_Q16 + t1_ff + t2_ff;
      case (cmd.sel)
         U_DEDX: begin
            div_num = 64'({ten_e, 16'b0});
            div_den = 64'(step_d);
         end
         default: begin
            div_num = 64'({energy_ff, 16'b0});
            div_den = den;
         end
      endcase
      case (cmd.sel)
         U_T1:    mul_a = 64'(k1_ff);
         U_Q:     mul_a = 64'(second_ff);
         default: mul_a = q_ff;
      endcase
   end

   bcea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quo)
   );

   bcea_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mcand   (mul_a),
      .mplier  (dedx_ff),
      .done    (mul_done),
      .product (prod)
   );

   // Table walk compare and read checks
   always_comb begin
      scan_hit  = scan_active_ff && rd_en_ff && (rd_cell_ff == cell_ff);
      scan_miss = scan_active_ff && !rd_en_ff && (addr_ff >= fill_ff);
      issue     = scan_active_ff && !scan_hit && (addr_ff < fill_ff);
      ri32      = 32'(ri_ff);
      read_ok   = ri32 < 32'(fill_ff);
      sum49     = {1'b0, rd_energy_ff} + 49'(corr_ff);
      sum_sat   = sum49[48] ? '1 : sum49[47:0];
      fill_idx  = fill_ff[IW-1:0];
   end

   always_comb begin
      status.cmd       = cmd_code_ff;
      status.e_zero    = energy_ff == 32'd0;
      status.no_corr   = (charge_ff == 5'sd0) || !match_ff || (len_ff == 24'd0)
                         || (rho_ff == 16'd0);
      status.div_done  = div_done;
      status.mul_done  = mul_done;
      status.scan_hit  = scan_hit;
      status.scan_miss = scan_miss;
      status.full      = fill_ff >= DEPTH_C;
      status.read_ok   = read_ok;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= FIRST_RESET;
         second_ff <= SECOND_RESET;
      end else if (csr_take) begin
         if (csr_index == REG_FIRST) begin
            first_ff <= csr_data[23:0];
         end else if (csr_index == REG_SECOND) begin
            second_ff <= csr_data;
         end
      end
   end

   // Capture request and unit results
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_code_ff <= CMD_NONE;
      end else if (in_take) begin
         cmd_code_ff <= command_type'(req_command);
      end
      if (in_take) begin
         cell_ff   <= req_cell_id;
         energy_ff <= req_energy_in;
         len_ff    <= req_step_length;
         rho_ff    <= req_density;
         charge_ff <= req_charge;
         match_ff  <= req_material_match;
         ri_ff     <= req_read_index;
         k1_ff     <= heavy_req ? k1_prod[K1_SHIFT +: 24] : first_ff;
      end
      if (cmd.div_start || cmd.mul_start) begin
         sel_ff <= cmd.sel;
      end
      if (div_done && (sel_ff == U_DEDX)) begin
         dedx_ff <= quo;
      end
      if (cmd.pass_energy) begin
         corr_ff <= energy_ff;
      end else if (div_done && (sel_ff == U_CORR)) begin
         corr_ff <= quo[31:0];
      end
      if (mul_done) begin
         case (sel_ff)
            U_T1:    t1_ff <= prod[87:24];
            U_Q:     q_ff  <= prod[95:32];
            default: t2_ff <= (prod[127:64] != 64'd0) ? T2_SAT : {16'b0, prod[63:16]};
         endcase
      end
   end

   // Walk control and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         rd_en_ff       <= 1'b0;
         addr_ff        <= '0;
         fill_ff        <= '0;
      end else begin
         if (cmd.scan_start) begin
            scan_active_ff <= 1'b1;
            rd_en_ff       <= 1'b0;
            addr_ff        <= '0;
         end else if (scan_active_ff) begin
            if (scan_hit || scan_miss) begin
               scan_active_ff <= 1'b0;
            end else begin
               rd_en_ff <= issue;
               if (issue) begin
                  addr_ff <= addr_ff + CW'(1);
               end
            end
         end
         if (cmd.out_load) begin
            if (cmd.out_status == ST_NEW) begin
               fill_ff <= fill_ff + CW'(1);
            end else if (cmd.out_status == ST_CLEARED) begin
               fill_ff <= '0;
            end
         end
      end
   end

   // Table memories: one read port, one write port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_cell_ff   <= cell_mem[addr_ff[IW-1:0]];
         rd_energy_ff <= energy_mem[addr_ff[IW-1:0]];
         rd_idx_ff    <= addr_ff[IW-1:0];
      end else if (cmd.read_start) begin
         rd_cell_ff   <= cell_mem[ri32[IW-1:0]];
         rd_energy_ff <= energy_mem[ri32[IW-1:0]];
         rd_idx_ff    <= ri32[IW-1:0];
      end
      if (cmd.out_load && (cmd.out_status == ST_MERGED)) begin
         energy_mem[rd_idx_ff] <= sum_sat;
      end else if (cmd.out_load && (cmd.out_status == ST_NEW)) begin
         cell_mem[fill_idx]   <= cell_ff;
         energy_mem[fill_idx] <= 48'(corr_ff);
      end
   end

   // Result register
   logic [31:0] idx32, fill32, fill_next32;
   always_comb begin
      idx32       = 32'(rd_idx_ff);
      fill32      = 32'(fill_ff);
      fill_next32 = fill32 + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         rsp_index_ff  <= '0;
         rsp_cell_ff   <= '0;
         rsp_energy_ff <= '0;
         rsp_corr_ff   <= '0;
         rsp_count_ff  <= fill32[10:0];
         case (cmd.out_status)
            ST_MERGED: begin
               rsp_index_ff  <= idx32[9:0];
               rsp_cell_ff   <= cell_ff;
               rsp_energy_ff <= sum_sat;
               rsp_corr_ff   <= corr_ff;
            end
            ST_NEW: begin
               rsp_index_ff  <= fill32[9:0];
               rsp_cell_ff   <= cell_ff;
               rsp_energy_ff <= 48'(corr_ff);
               rsp_corr_ff   <= corr_ff;
               rsp_count_ff  <= fill_next32[10:0];
            end
            ST_FULL: begin
               rsp_corr_ff <= corr_ff;
            end
            ST_READ_OK: begin
               rsp_index_ff  <= ri_ff;
               rsp_cell_ff   <= rd_cell_ff;
               rsp_energy_ff <= rd_energy_ff;
            end
            ST_READ_OOR: begin
               rsp_index_ff <= ri_ff;
            end
            ST_CLEARED: begin
               rsp_count_ff <= '0;
            end
            default: begin
               rsp_index_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_index      = rsp_index_ff;
   assign rsp_entry_cell       = rsp_cell_ff;
   assign rsp_entry_energy     = rsp_energy_ff;
   assign rsp_corrected_energy = rsp_corr_ff;
   assign rsp_entry_count      = rsp_count_ff;

endmodule

[hdl/bcea_ctrl.sv]
// Controller: sequences decode, quenching arithmetic, table walk, reads and result transfer.
// Depends on bcea_pkg.
module bcea_ctrl import bcea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DEDX, S_T1, S_Q, S_T2, S_CORR,
      S_SCAN, S_READ, S_DONE
   } state_type;

   state_type    state_ff, state_in;
   ctrl_cmd_type cmd_ff, cmd_in;

   // Next state and next command pulses
   always_comb begin
      state_in              = state_ff;
      cmd_in                = '0;
      cmd_in.sel            = cmd_ff.sel;
      cmd_in.out_status     = cmd_ff.out_status;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.cmd)
               CMD_DEPOSIT: begin
                  if (status.e_zero) begin
                     cmd_in.out_status = ST_ZERO;
                     state_in          = S_DONE;
                  end else if (status.no_corr) begin
                     cmd_in.pass_energy = 1'b1;
                     cmd_in.scan_start  = 1'b1;
                     state_in           = S_SCAN;
                  end else begin
                     cmd_in.div_start = 1'b1;
                     cmd_in.sel       = U_DEDX;
                     state_in         = S_DEDX;
                  end
               end
               CMD_READ: begin
                  if (status.read_ok) begin
                     cmd_in.read_start = 1'b1;
                     state_in          = S_READ;
                  end else begin
                     cmd_in.out_status = ST_READ_OOR;
                     state_in          = S_DONE;
                  end
               end
               CMD_CLEAR: begin
                  cmd_in.out_status = ST_CLEARED;
                  state_in          = S_DONE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DEDX: begin
            if (status.div_done) begin
               cmd_in.mul_start = 1'b1;
               cmd_in.sel       = U_T1;
               state_in         = S_T1;
            end
         end
         S_T1: begin
            if (status.mul_done) begin
               cmd_in.mul_start = 1'b1;
               cmd_in.sel       = U_Q;
               state_in         = S_Q;
            end
         end
         S_Q: begin
            if (status.mul_done) begin
               cmd_in.mul_start = 1'b1;
               cmd_in.sel       = U_T2;
               state_in         = S_T2;
            end
         end
         S_T2: begin
            if (status.mul_done) begin
               cmd_in.div_start = 1'b1;
               cmd_in.sel       = U_CORR;
               state_in         = S_CORR;
            end
         end
         S_CORR: begin
            if (status.div_done) begin
               cmd_in.scan_start = 1'b1;
               state_in          = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.scan_hit) begin
               cmd_in.out_status = ST_MERGED;
               state_in          = S_DONE;
            end else if (status.scan_miss) begin
               cmd_in.out_status = status.full ? ST_FULL : ST_NEW;
               state_in          = S_DONE;
            end
         end
         S_READ: begin
            cmd_in.out_status = ST_READ_OK;
            state_in          = S_DONE;
         end
         S_DONE: begin
            // Hold until the result register is free, then transfer
            if (status.out_free) begin
               cmd_in.out_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign cmd       = cmd_ff;

endmodule

[verif/testbench.sv]
// Self-checking testbench of the Birks corrected cell energy aggregator.
// Drives deposit, read and clear commands, predicts every result in place.
// Depends on bcea_pkg and birks_corrected_cell_energy_aggregator.
`timescale 1ns / 100ps

module testbench;
   import bcea_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int DRAIN_CYCLES = 1200;
   localparam int WATCHDOG_MAX = 20000;
   localparam int RANDOM_ITEMS = 450;
   localparam logic [47:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      command_type      cmd;
      logic [63:0]      cell_id;
      logic [31:0]      energy;
      logic [23:0]      step;
      logic [15:0]      dens;
      logic signed [4:0] chg;
      logic             match;
      logic [9:0]       ridx;
   } deposit_cmd_type;

   typedef struct {
      status_type  st;
      logic [9:0]  idx;
      logic [63:0] entry_cell;
      logic [47:0] energy;
      logic [31:0] corr;
      logic [10:0] count;
   } cell_result_type;

   typedef struct {
      deposit_cmd_type cmd;
      bit              typed;
      cell_result_type res;
   } directed_row_type;

   localparam cell_result_type NO_RESULT = '{ST_ZERO, 10'd0, 64'd0, 48'd0, 32'd0, 11'd0};

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_command;
   logic [63:0] req_cell_id;
   logic [31:0] req_energy_in;
   logic [23:0] req_step_length;
   logic [15:0] req_density;
   logic signed [4:0] req_charge;
   logic req_material_match;
   logic [9:0] req_read_index;
   logic rsp_valid, rsp_ready;
   logic [2:0] rsp_status;
   logic [9:0] rsp_entry_index;
   logic [63:0] rsp_entry_cell;
   logic [47:0] rsp_entry_energy;
   logic [31:0] rsp_corrected_energy;
   logic [10:0] rsp_entry_count;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   // Predictor state
   logic [63:0] cell_table [DEPTH];
   logic [47:0] energy_table [DEPTH];
   int          filled;
   logic [63:0] kb_first, kb_second;

   cell_result_type expected_results[$];
   int  mismatches;
   bit  idling_on;
   int  stall_left;
   int  quiet_cycles;
   logic [63:0] cell_pool [16];
   directed_row_type rows[$];

   always #5 clock = ~clock;

   birks_corrected_cell_energy_aggregator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_cell_id(req_cell_id), .req_energy_in(req_energy_in),
      .req_step_length(req_step_length), .req_density(req_density),
      .req_charge(req_charge), .req_material_match(req_material_match),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index), .rsp_entry_cell(rsp_entry_cell),
      .rsp_entry_energy(rsp_entry_energy), .rsp_corrected_energy(rsp_corrected_energy),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Birks quenching of one deposit in fixed point
   function automatic logic [31:0] birks_quench(deposit_cmd_type c);
      logic [63:0] e, d, dedx, k1, t1, q, t2, den;
      e = 64'(c.energy);
      if (c.chg == 0 || !c.match || c.step == 0 || c.dens == 0) return c.energy;
      d    = 64'(c.step) * 64'(c.dens);
      dedx = ((64'd10 * e) << 16) / d;
      k1   = kb_first;
      if (c.chg > 1 || c.chg < -1) k1 = (k1 * 64'd4) / 64'd7;
      t1 = k1 * (dedx >> 24) + ((k1 * (dedx & 64'hFF_FFFF)) >> 24);
      q  = kb_second * (dedx >> 32) + ((kb_second * (dedx & 64'hFFFF_FFFF)) >> 32);
      if (q == 0 || dedx == 0)
         t2 = 64'd0;
      else if (dedx > 64'hFFFF_FFFF_FFFF_FFFF / q)
         t2 = T2_SAT;
      else begin
         t2 = (q * dedx) >> 16;
         if (t2 > T2_SAT) t2 = T2_SAT;
      end
      den = ONE_Q16 + t1 + t2;
      return 32'((e << 16) / den);
   endfunction

   // Advance the cell table by one command; returns 0 when no result follows
   function automatic bit aggregate(deposit_cmd_type c, output cell_result_type r);
      logic [31:0] corr;
      logic [63:0] sum;
      r = NO_RESULT;
      case (c.cmd)
         CMD_NONE: return 0;
         CMD_READ: begin
            r.idx = c.ridx;
            if (int'(c.ridx) < filled) begin
               r.st = ST_READ_OK;
               r.entry_cell = cell_table[c.ridx];
               r.energy = energy_table[c.ridx];
            end else
               r.st = ST_READ_OOR;
         end
         CMD_CLEAR: begin
            filled = 0;
            r.st = ST_CLEARED;
         end
         default: begin
            if (c.energy != 0) begin
               corr = birks_quench(c);
               r.corr = corr;
               r.st = ST_FULL;
               for (int i = 0; i < filled; i++)
                  if (r.st == ST_FULL && cell_table[i] == c.cell_id) begin
                     sum = 64'(energy_table[i]) + 64'(corr);
                     if (sum > 64'(ENERGY_MAX)) sum = 64'(ENERGY_MAX);
                     energy_table[i] = sum[47:0];
                     r = '{ST_MERGED, 10'(i), c.cell_id, sum[47:0], corr, 11'd0};
                  end
               if (r.st == ST_FULL && filled < DEPTH) begin
                  cell_table[filled] = c.cell_id;
                  energy_table[filled] = 48'(corr);
                  r = '{ST_NEW, 10'(filled), c.cell_id, 48'(corr), corr, 11'd0};
                  filled++;
               end
            end
         end
      endcase
      r.count = 11'(filled);
      return 1;
   endfunction

   function automatic deposit_cmd_type make_cmd(command_type cmd, logic [63:0] cell_id,
         logic [31:0] e, logic [23:0] l, logic [15:0] rho, int chg, bit m, int ri);
      deposit_cmd_type c;
      c = '{cmd, cell_id, e, l, rho, 5'(chg), m, 10'(ri)};
      return c;
   endfunction

   // Random command, mostly deposits, biased toward a small pool of cells for merges
   function automatic deposit_cmd_type random_cmd();
      deposit_cmd_type c;
      int pick;
      pick = $urandom_range(0, 99);
      c = make_cmd(CMD_DEPOSIT, {$urandom, $urandom}, $urandom >> $urandom_range(0, 31),
                   24'($urandom) >> $urandom_range(0, 23),
                   16'($urandom) >> $urandom_range(0, 15), $urandom_range(0, 16) - 8,
                   $urandom_range(0, 5) != 0, $urandom_range(0, 1023));
      if (c.dens == 0) c.dens = 16'd1;
      if ($urandom_range(0, 2) != 0) c.cell_id = cell_pool[$urandom_range(0, 15)];
      if ($urandom_range(0, 15) == 0) c.energy = 32'd0;
      if (pick < 12) begin
         c.cmd = CMD_READ;
         if ($urandom_range(0, 3) != 0) c.ridx = 10'($urandom_range(0, filled + 2));
      end else if (pick < 15)
         c.cmd = CMD_CLEAR;
      else if (pick < 17)
         c.cmd = CMD_NONE;
      return c;
   endfunction

   function automatic void check_result(cell_result_type got);
      cell_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Unexpected result: status %0d index %0d", got.st, got.idx);
         return;
      end
      want = expected_results.pop_front();
      if (got.st != want.st || got.idx != want.idx || got.entry_cell != want.entry_cell ||
          got.energy != want.energy || got.corr != want.corr || got.count != want.count) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch expected: st %0d idx %0d cell %h energy %h corr %h count %0d",
                     want.st, want.idx, want.entry_cell, want.energy, want.corr, want.count);
            $display("           actual: st %0d idx %0d cell %h energy %h corr %h count %0d",
                     got.st, got.idx, got.entry_cell, got.energy, got.corr, got.count);
         end
      end
   endfunction

   // Present one command, hold it until the transfer, then predict
   task automatic send_cmd(deposit_cmd_type c, bit typed = 0,
                           cell_result_type typed_res = NO_RESULT);
      cell_result_type r;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c.cmd;
      req_cell_id <= c.cell_id;
      req_energy_in <= c.energy;
      req_step_length <= c.step;
      req_density <= c.dens;
      req_charge <= c.chg;
      req_material_match <= c.match;
      req_read_index <= c.ridx;
      do @(posedge clock); while (!req_ready);
      if (aggregate(c, r)) expected_results.push_back(typed ? typed_res : r);
   endtask

   // Drain all results, then let a command without a result finish
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_birks(logic [23:0] first, logic [31:0] second);
      csr_valid <= 1'b1;
      csr_index <= REG_FIRST;
      csr_data <= 32'(first);
      do @(posedge clock); while (!csr_ready);
      kb_first = 64'(first);
      csr_index <= REG_SECOND;
      csr_data <= second;
      do @(posedge clock); while (!csr_ready);
      kb_second = 64'(second);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int n);
      repeat (n) send_cmd(random_cmd());
   endtask

   // Result channel stalls in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= 1'b1;
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result('{status_type'(rsp_status), rsp_entry_index, rsp_entry_cell,
                        rsp_entry_energy, rsp_corrected_energy, rsp_entry_count});
   end

   // Watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("Regression FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_NONE;
      req_cell_id <= '0;
      req_energy_in <= '0;
      req_step_length <= '0;
      req_density <= 16'd1;
      req_charge <= '0;
      req_material_match <= 1'b0;
      req_read_index <= '0;
      rsp_ready <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= REG_FIRST;
      csr_data <= '0;
      mismatches = 0;
      stall_left = 0;
      quiet_cycles = 0;
      idling_on = 1'b1;
      filled = 0;
      kb_first = 64'(FIRST_RESET);
      kb_second = 64'(SECOND_RESET);
      cell_pool[0] = '0;
      cell_pool[1] = '1;
      for (int i = 2; i < 16; i++) cell_pool[i] = {$urandom, $urandom};

      // Directed rows: reset state, extremes, every command, corner cases
      rows.push_back('{make_cmd(CMD_READ, 0, 0, 0, 1, 0, 0, 0), 1,
                       '{ST_READ_OOR, 10'd0, 64'd0, 48'd0, 32'd0, 11'd0}});
      rows.push_back('{make_cmd(CMD_CLEAR, '1, '1, '1, '1, 8, 1, 1023), 1,
                       '{ST_CLEARED, 10'd0, 64'd0, 48'd0, 32'd0, 11'd0}});
      rows.push_back('{make_cmd(CMD_DEPOSIT, '1, 0, 1, 1, 1, 1, 0), 1,
                       '{ST_ZERO, 10'd0, 64'd0, 48'd0, 32'd0, 11'd0}});
      rows.push_back('{make_cmd(CMD_DEPOSIT, '1, '1, '1, '1, 0, 1, 0), 1,
                       '{ST_NEW, 10'd0, '1, 48'hFFFF_FFFF, '1, 11'd1}});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 0, 1, 5, 5, 3, 0, 0), 1,
                       '{ST_NEW, 10'd1, 64'd0, 48'd1, 32'd1, 11'd2}});
      rows.push_back('{make_cmd(CMD_READ, 0, 0, 0, 1, 0, 0, 1023), 1,
                       '{ST_READ_OOR, 10'd1023, 64'd0, 48'd0, 32'd0, 11'd2}});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 64'h5, '1, 1, 1, 1, 1, 0), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 64'h6, 1, '1, '1, -8, 1, 0), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 64'h7, 1000, 0, 100, 8, 1, 0), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 64'h8, 3, 1, 1, -1, 1, 0), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_DEPOSIT, '1, 5_000_000, 300, 1032, 2, 1, 0), 0,
                       NO_RESULT});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 64'h5, 123456, 1000, 1032, -2, 1, 0), 0,
                       NO_RESULT});
      rows.push_back('{make_cmd(CMD_NONE, 64'h9, 77, 1, 1, 1, 1, 0), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_READ, 0, 0, 0, 1, 0, 0, 0), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_READ, 0, 0, 0, 1, 0, 0, 2), 0, NO_RESULT});
      rows.push_back('{make_cmd(CMD_DEPOSIT, 64'h8, 0, 1, 1, 1, 1, 0), 0, NO_RESULT});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);
      random_phase(150);

      // Extreme constants; the drain doubles as the pause for all results
      drain();
      write_birks(24'hFF_FFFF, 32'hFFFF_FFFF);
      random_phase(100);
      drain();
      write_birks(24'd0, 32'd0);
      random_phase(60);
      drain();
      write_birks(24'($urandom), $urandom >> $urandom_range(0, 20));
      random_phase(60);

      // Last part at reset constants and without idling
      drain();
      write_birks(FIRST_RESET, SECOND_RESET);
      idling_on = 1'b0;
      random_phase(RANDOM_ITEMS - 370);
      drain();

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
